>>> hdl/srmu_pkg.sv
// ----------------------------------------------------------------------------
// srmu_pkg
// Shared types and constants for the special register move unit.
// ----------------------------------------------------------------------------
package srmu_pkg;

	typedef enum logic [3:0] {
		CMD_MFSPR  = 4'd0,
		CMD_MTSPR  = 4'd1,
		CMD_MFTB   = 4'd2,
		CMD_MFMSR  = 4'd3,
		CMD_MTMSR  = 4'd4,
		CMD_MFSR   = 4'd5,
		CMD_MTSR   = 4'd6,
		CMD_MFSRIN = 4'd7,
		CMD_MTSRIN = 4'd8
	} cmd_t;

	localparam logic [9:0] SPR_XER  = 10'd1;
	localparam logic [9:0] SPR_LR   = 10'd8;
	localparam logic [9:0] SPR_CTR  = 10'd9;
	localparam logic [9:0] SPR_UTBL = 10'd268;
	localparam logic [9:0] SPR_UTBU = 10'd269;
	// UGQR0..UGQR7 occupy 896..903: upper seven bits fixed
	localparam logic [6:0] SPR_UGQR_BASE = 7'd112;

	// Operation presented to the register file
	typedef struct packed {
		logic        en;
		cmd_t        cmd;
		logic [9:0]  spr_num;
		logic [3:0]  seg;
		logic [31:0] src;
		logic [63:0] tb;
	} srmu_req_t;

	// Result of one operation
	typedef struct packed {
		logic [31:0] value;
		logic        write;
		logic        bad;
	} srmu_rsp_t;

	// Raw instruction field has its two 5-bit halves swapped
	function automatic logic [9:0] swap_halves(input logic [9:0] f);
		return {f[4:0], f[9:5]};
	endfunction

endpackage

>>> hdl/srmu_regfile.sv
// ----------------------------------------------------------------------------
// srmu_regfile
// Special register file (XER, LR, CTR, GQRs, MSR, SRs) with the
// read/write decode for one move operation.
// ----------------------------------------------------------------------------
module srmu_regfile (
	input  logic                clk,
	input  logic                arst_n,
	input  srmu_pkg::srmu_req_t req,
	output srmu_pkg::srmu_rsp_t rsp
);
	import srmu_pkg::*;

	logic [31:0] xer_q;
	logic [31:0] lr_q;
	logic [31:0] ctr_q;
	logic [31:0] msr_q;
	logic [31:0] gqr_q [8];
	logic [31:0] sr_q  [16];

	logic        gqr_hit;
	logic        spr_hit;
	logic [31:0] spr_rdata;
	logic [31:0] tb_rdata;
	logic        tb_hit;

	assign gqr_hit = (req.spr_num[9:3] == SPR_UGQR_BASE);

	always_comb begin
		spr_hit   = 1'b1;
		spr_rdata = '0;
		unique case (req.spr_num)
			SPR_XER: spr_rdata = xer_q;
			SPR_LR:  spr_rdata = lr_q;
			SPR_CTR: spr_rdata = ctr_q;
			default: begin
				if (gqr_hit) begin
					spr_rdata = gqr_q[req.spr_num[2:0]];
				end else begin
					spr_hit = 1'b0;
				end
			end
		endcase
	end

	always_comb begin
		tb_hit   = 1'b1;
		tb_rdata = '0;
		unique case (req.spr_num)
			SPR_UTBL: tb_rdata = req.tb[31:0];
			SPR_UTBU: tb_rdata = req.tb[63:32];
			default:  tb_hit = 1'b0;
		endcase
	end

	always_comb begin
		rsp = '0;
		unique case (req.cmd) inside
			CMD_MFSPR: begin
				rsp.value = spr_rdata;
				rsp.write = 1'b1;
				rsp.bad   = !spr_hit;
			end
			CMD_MTSPR: rsp.bad = !spr_hit;
			CMD_MFTB: begin
				rsp.value = tb_rdata;
				rsp.write = 1'b1;
				rsp.bad   = !tb_hit;
			end
			CMD_MFMSR: begin
				rsp.value = msr_q;
				rsp.write = 1'b1;
			end
			CMD_MFSR, CMD_MFSRIN: begin
				rsp.value = sr_q[req.seg];
				rsp.write = 1'b1;
			end
			default: rsp = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xer_q <= '0;
			lr_q  <= '0;
			ctr_q <= '0;
			msr_q <= '0;
			for (int i = 0; i < 8; i++) gqr_q[i] <= '0;
			for (int i = 0; i < 16; i++) sr_q[i] <= '0;
		end else if (req.en) begin
			unique case (req.cmd) inside
				CMD_MTSPR: begin
					unique case (req.spr_num)
						SPR_XER: xer_q <= req.src;
						SPR_LR:  lr_q  <= req.src;
						SPR_CTR: ctr_q <= req.src;
						default: begin
							if (gqr_hit) gqr_q[req.spr_num[2:0]] <= req.src;
						end
					endcase
				end
				CMD_MTMSR:             msr_q <= req.src;
				CMD_MTSR, CMD_MTSRIN:  sr_q[req.seg] <= req.src;
				default: ;
			endcase
		end
	end

endmodule

>>> hdl/special_register_move_unit_core.sv
// ----------------------------------------------------------------------------
// special_register_move_unit_core
// PowerPC special register move unit: mfspr/mtspr, mftb, mfmsr/mtmsr,
// mfsr/mtsr, mfsrin/mtsrin against a private register file.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle when not stalled and returns exactly one
// result per transaction, in order. Each passes the input register, then the
// register file read/update and the result register. The register file is
// read and written in the same stage, so each move sees every earlier move.
// out_stall backs up into in_stall through the input register only; while
// the result register is empty, in_stall stays low. An unsupported SPR/TBR
// number raises bad_register; reads of it return zero, writes are dropped.
module special_register_move_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  cmd,
	input  logic [9:0]  spr_field,
	input  logic [3:0]  segment_number,
	input  logic [31:0] source_value,
	input  logic [31:0] index_value,
	input  logic [63:0] time_base,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] dest_value,
	output logic        dest_write,
	output logic        bad_register
);
	import srmu_pkg::*;

	logic        vld_s1;
	cmd_t        cmd_s1;
	logic [9:0]  spr_num_s1;
	logic [3:0]  seg_s1;
	logic [31:0] src_s1;
	logic [63:0] tb_s1;

	logic        vld_s2;
	srmu_rsp_t   rsp_s2;

	logic        out_ready;
	logic        advance;
	logic        in_acc;
	logic [3:0]  seg_sel;
	srmu_req_t   req;
	srmu_rsp_t   rsp;

	assign out_ready = !vld_s2 || !out_stall;
	assign advance   = vld_s1 && out_ready;
	assign in_stall  = vld_s1 && !out_ready;
	assign in_acc    = in_valid && !in_stall;

	// indirect forms take the segment from rB
	assign seg_sel = (cmd == CMD_MFSRIN || cmd == CMD_MTSRIN) ? index_value[3:0]
	                                                          : segment_number;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1     <= cmd_t'(cmd);
			spr_num_s1 <= swap_halves(spr_field);
			seg_s1     <= seg_sel;
			src_s1     <= source_value;
			tb_s1      <= time_base;
		end
	end

	always_comb begin
		req.en      = advance;
		req.cmd     = cmd_s1;
		req.spr_num = spr_num_s1;
		req.seg     = seg_s1;
		req.src     = src_s1;
		req.tb      = tb_s1;
	end

	srmu_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) rsp_s2 <= rsp;
	end

	assign out_valid    = vld_s2;
	assign dest_value   = rsp_s2.value;
	assign dest_write   = rsp_s2.write;
	assign bad_register = rsp_s2.bad;

endmodule

>>> hdl/srmu_checker.sv
// ----------------------------------------------------------------------------
// srmu_checker
// Port-level checks for the special register move unit, bound to the core.
// ----------------------------------------------------------------------------
module srmu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] dest_value,
	input logic        dest_write,
	input logic        bad_register
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(dest_value)
			&& $stable(dest_write) && $stable(bad_register))
		else $error("result changed while stalled");

	// moves that do not write rD, and unknown registers, give zero
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (!dest_write || bad_register) |-> dest_value == 32'd0)
		else $error("nonzero dest_value without a valid read");

	// empty result register never blocks input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("in_stall with empty output");

	// accepted transaction moves from the input register to the output when out_stall is low while it waits there
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("result missing after accepted transaction");

endmodule

bind special_register_move_unit_core srmu_checker u_srmu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.dest_value   (dest_value),
	.dest_write   (dest_write),
	.bad_register (bad_register)
);
